// File: design/bbr_pkg.sv
// Shared constants for the boot block receiver: field widths, word layouts and codes.
package bbr_pkg;

	// Default geometry of one page transfer.
	localparam int BLOCK_BYTES_DEF      = 256;
	localparam int FRAMES_PER_BLOCK_DEF = 32;

	// Field widths.
	localparam int CLASS_W   = 9;
	localparam int TYPE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int BYTE_W    = 8;
	localparam int NBYTES    = 8;
	localparam int KIND_W    = 2;
	localparam int PAGE_W    = 16;
	localparam int CHUNK_W   = 5;
	localparam int CHUNK_D_W = BYTE_W * NBYTES;

	// Word layouts on the stream ports.
	localparam int IN_USER_W  = CLASS_W + TYPE_W;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_USER_W = KIND_W;
	localparam int OUT_DATA_W = 88;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_CLASS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TYPE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_TYPE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE_TYPE  = 3'd4;

	localparam logic [CLASS_W-1:0] PROTOCOL_CLASS_RST = 9'd0;
	localparam logic [TYPE_W-1:0]  START_TYPE_RST     = 8'd15;
	localparam logic [TYPE_W-1:0]  DATA_TYPE_RST      = 8'd16;
	localparam logic [TYPE_W-1:0]  PROGRAM_TYPE_RST   = 8'd19;
	localparam logic [TYPE_W-1:0]  ACTIVATE_TYPE_RST  = 8'd22;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_BLOCK_ACK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAGE_CHUNK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PROGRAM_ACK = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ACTIVATE    = 2'd3;

	// Largest byte count one data message may carry.
	localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

endpackage

// File: design/boot_block_receiver.sv
// Boot block receiver: collects a page of firmware data and streams it back for programming.
//
// Results: a message that gives a single result (block acknowledge or activate) shows it on the
// output in the cycle after the word is taken. A program message streams BLOCK_BYTES/8 chunks,
// each read through the registered port of the page memory before it is sent, then the program
// acknowledge; the output register holds each word until the sink takes it.
// Input: any other message is taken whenever the output register is free and no page streams out.
// Reset (arst_n low, asynchronous): idle phase, registers at their defaults, all row valid bits
// cleared, so every page row reads as zero until a data message writes it.
module boot_block_receiver #(
	parameter int BLOCK_BYTES      = bbr_pkg::BLOCK_BYTES_DEF,
	parameter int FRAMES_PER_BLOCK = bbr_pkg::FRAMES_PER_BLOCK_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bbr_pkg::CFG_DATA_W-1:0]  cfg_data,

	// Received messages.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, low bit up: data_len[3:0], byte0 .. byte7, 4 bits of zero fill.
	input  logic [bbr_pkg::IN_DATA_W-1:0]   s_tdata,
	// s_tuser, low bit up: msg_class[8:0], msg_type[16:9].
	input  logic [bbr_pkg::IN_USER_W-1:0]   s_tuser,

	// Results.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, low bit up: page_number[15:0], chunk_index[20:16], chunk_data[84:21],
	// 3 bits of zero fill.
	output logic [bbr_pkg::OUT_DATA_W-1:0]  m_tdata,
	// m_tuser, low bit up: kind[1:0].
	output logic [bbr_pkg::OUT_USER_W-1:0]  m_tuser,
	// m_tlast: high on the final word caused by one message.
	output logic                            m_tlast
);
	import bbr_pkg::*;

	// The page memory holds one 64-bit row per eight-byte chunk. A data frame that fits in the page
	// lands on exactly one row, since its bytes start at frame*8.
	localparam int CHUNKS = BLOCK_BYTES / NBYTES;
	localparam int AW     = $clog2(CHUNKS);
	localparam int FW     = $clog2(FRAMES_PER_BLOCK + 1);

	// Phases of the transfer, plus two states that stream the page back out.
	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_COLLECT = 6'b000010,
		ST_WAIT    = 6'b000100,
		ST_READ    = 6'b001000,
		ST_ACK     = 6'b010000,
		ST_LOCKED  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CLASS_W-1:0] protocol_class_q;
	logic [TYPE_W-1:0]  start_type_q;
	logic [TYPE_W-1:0]  data_type_q;
	logic [TYPE_W-1:0]  program_type_q;
	logic [TYPE_W-1:0]  activate_type_q;

	// Transfer state.
	logic [PAGE_W-1:0]  page_q;
	logic [FW-1:0]      frame_q;
	logic [CHUNKS-1:0]  row_vld_q;
	logic [AW-1:0]      rd_idx_q;
	logic               rd_ok_q;

	// Page memory and its registered read port.
	logic [CHUNK_D_W-1:0] page_mem_q [CHUNKS];
	logic [CHUNK_D_W-1:0] rd_data_s1;
	logic                 rd_vld_s1;

	// Output register.
	logic                 out_vld_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic [PAGE_W-1:0]    out_page_q;
	logic [CHUNK_W-1:0]   out_idx_q;
	logic [CHUNK_D_W-1:0] out_data_q;
	logic                 out_last_q;

	// Unpacked input fields.
	logic [CLASS_W-1:0]   msg_class;
	logic [TYPE_W-1:0]    msg_type;
	logic [LEN_W-1:0]     data_len;
	logic [CHUNK_D_W-1:0] msg_bytes;
	logic [LEN_W-1:0]     len_clamped;

	logic                 out_free;
	logic                 in_take;
	logic                 proto_msg;

	// Write port of the page memory.
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [NBYTES-1:0]    wr_be;
	logic [CHUNK_D_W-1:0] wr_data;

	assign msg_class = s_tuser[CLASS_W-1:0];
	assign msg_type  = s_tuser[CLASS_W +: TYPE_W];
	assign data_len  = s_tdata[LEN_W-1:0];
	assign msg_bytes = s_tdata[LEN_W +: CHUNK_D_W];

	assign len_clamped = (data_len > MAX_LEN) ? MAX_LEN : data_len;

	// The output register can take a new word when empty or when its word leaves this cycle.
	assign out_free  = !out_vld_q || m_tready;
	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q inside {ST_IDLE, ST_COLLECT, ST_WAIT, ST_LOCKED}) && out_free;
	assign in_take   = s_tvalid && s_tready;
	assign proto_msg = (msg_class == protocol_class_q);

	// A data frame writes the row at its frame number; frames past the page end are dropped.
	// A row never written before reads as zero, so its first write fills the unused bytes
	// with zeros instead of leaving them to the old memory contents.
	always_comb begin
		wr_en   = in_take && proto_msg && (state_q == ST_COLLECT) && (msg_type == data_type_q)
		          && (32'(frame_q) < CHUNKS);
		wr_addr = AW'(frame_q);
		for (int b = 0; b < NBYTES; b++) begin
			if (4'(b) < len_clamped) begin
				wr_data[BYTE_W*b +: BYTE_W] = msg_bytes[BYTE_W*b +: BYTE_W];
				wr_be[b] = 1'b1;
			end else begin
				wr_data[BYTE_W*b +: BYTE_W] = '0;
				wr_be[b] = !row_vld_q[wr_addr];
			end
		end
	end

	// Writes happen only while collecting; the read port samples every cycle, but its word is used
	// only while streaming out, when no write can happen.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int b = 0; b < NBYTES; b++) begin
				if (wr_be[b]) begin
					page_mem_q[wr_addr][BYTE_W*b +: BYTE_W] <= wr_data[BYTE_W*b +: BYTE_W];
				end
			end
		end
		rd_data_s1 <= page_mem_q[rd_idx_q];
		rd_vld_s1  <= row_vld_q[rd_idx_q];
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_class_q <= PROTOCOL_CLASS_RST;
			start_type_q     <= START_TYPE_RST;
			data_type_q      <= DATA_TYPE_RST;
			program_type_q   <= PROGRAM_TYPE_RST;
			activate_type_q  <= ACTIVATE_TYPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROTOCOL_CLASS: protocol_class_q <= cfg_data;
				REG_START_TYPE:     start_type_q     <= cfg_data[TYPE_W-1:0];
				REG_DATA_TYPE:      data_type_q      <= cfg_data[TYPE_W-1:0];
				REG_PROGRAM_TYPE:   program_type_q   <= cfg_data[TYPE_W-1:0];
				REG_ACTIVATE_TYPE:  activate_type_q  <= cfg_data[TYPE_W-1:0];
				default: ;
			endcase
		end
	end

	// Control sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			page_q     <= '0;
			frame_q    <= '0;
			row_vld_q  <= '0;
			rd_idx_q   <= '0;
			rd_ok_q    <= 1'b0;
			out_vld_q  <= 1'b0;
			out_kind_q <= KIND_BLOCK_ACK;
			out_page_q <= '0;
			out_idx_q  <= '0;
			out_data_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take && proto_msg) begin
						if (msg_type == start_type_q) begin
							// Page number arrives high byte first.
							page_q  <= {msg_bytes[7:0], msg_bytes[15:8]};
							frame_q <= '0;
							state_q <= ST_COLLECT;
						end else if (msg_type == activate_type_q) begin
							out_vld_q  <= 1'b1;
							out_kind_q <= KIND_ACTIVATE;
							out_page_q <= page_q;
							out_idx_q  <= '0;
							out_data_q <= '0;
							out_last_q <= 1'b1;
							state_q    <= ST_LOCKED;
						end
					end
				end
				ST_COLLECT: begin
					if (in_take && proto_msg && (msg_type == data_type_q)) begin
						if (frame_q == FW'(FRAMES_PER_BLOCK - 1)) begin
							// Last frame of the page: acknowledge the block.
							frame_q    <= '0;
							out_vld_q  <= 1'b1;
							out_kind_q <= KIND_BLOCK_ACK;
							out_page_q <= page_q;
							out_idx_q  <= '0;
							out_data_q <= '0;
							out_last_q <= 1'b1;
							state_q    <= ST_WAIT;
						end else begin
							frame_q <= frame_q + 1'b1;
						end
					end
				end
				ST_WAIT: begin
					if (in_take && proto_msg && (msg_type == program_type_q)) begin
						rd_idx_q <= '0;
						rd_ok_q  <= 1'b0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					// The memory word for rd_idx_q is ready in the cycle after the address settles.
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else if (out_free) begin
						out_vld_q  <= 1'b1;
						out_kind_q <= KIND_PAGE_CHUNK;
						out_page_q <= page_q;
						out_idx_q  <= CHUNK_W'(rd_idx_q);
						out_data_q <= rd_vld_s1 ? rd_data_s1 : '0;
						out_last_q <= 1'b0;
						rd_ok_q    <= 1'b0;
						if (rd_idx_q == AW'(CHUNKS - 1)) begin
							state_q <= ST_ACK;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				ST_ACK: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_kind_q <= KIND_PROGRAM_ACK;
						out_page_q <= page_q;
						out_idx_q  <= '0;
						out_data_q <= '0;
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_LOCKED: begin
					// Every message is taken and dropped until reset.
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_W - PAGE_W - CHUNK_W - CHUNK_D_W){1'b0}},
	                   out_data_q, out_idx_q, out_page_q};

endmodule
